/* design/sft_pkg.sv */
`timescale 1ns / 1ps
package sft_pkg;

  localparam int CONNECTIONS    = 16;
  localparam int SEQ_W          = 16;
  localparam int OP_W           = 3;
  localparam int CONN_W         = 4;
  localparam int WORD_W         = 64;
  localparam int BIT_W          = 6;
  localparam int WIDX_W         = SEQ_W - BIT_W;
  localparam int WORDS_PER_CONN = 1 << WIDX_W;
  localparam int CONN_IDX_W     = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int BM_ADDR_W      = CONN_IDX_W + WIDX_W;
  localparam int BM_DEPTH       = CONNECTIONS * WORDS_PER_CONN;

  localparam logic [OP_W-1:0] OP_SYNC     = 3'd0;
  localparam logic [OP_W-1:0] OP_SEND_REL = 3'd1;
  localparam logic [OP_W-1:0] OP_SEND_STR = 3'd2;
  localparam logic [OP_W-1:0] OP_RECV_REL = 3'd3;
  localparam logic [OP_W-1:0] OP_RECV_STR = 3'd4;

  // per-connection counter entry, one memory word
  typedef struct packed {
    logic [SEQ_W-1:0] rel_sent;
    logic [SEQ_W-1:0] str_sent;
    logic [SEQ_W-1:0] rel_recv;
    logic [SEQ_W-1:0] str_recv;
  } cnt_t;

  typedef struct packed {
    logic             fresh;
    logic [SEQ_W-1:0] assigned_number;
    logic [SEQ_W-1:0] peer_last;
  } res_t;

  // a is cyclically newer than b
  function automatic logic is_newer(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

endpackage

/* design/sft_ram.sv */
`timescale 1ns / 1ps
module sft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/sft_engine.sv */
`timescale 1ns / 1ps
module sft_engine
  import sft_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [CONN_W-1:0] in_conn,
  input  logic [SEQ_W-1:0]  in_seq,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0]            state;
  logic [BM_ADDR_W-1:0]  clr_addr;

  logic [OP_W-1:0]       op_r;
  logic [CONN_IDX_W-1:0] conn_r;
  logic                  conn_ok_r;
  logic [SEQ_W-1:0]      seq_r;

  logic [WIDX_W-1:0]     fill_word;
  logic [WIDX_W-1:0]     fill_end;
  logic [BIT_W-1:0]      fill_lo;
  logic [BIT_W-1:0]      fill_hi;
  logic                  fill_first;

  logic                  cnt_we, cnt_re;
  logic [CONN_IDX_W-1:0] cnt_waddr, cnt_raddr;
  logic [$bits(cnt_t)-1:0] cnt_wdata, cnt_rdata;

  logic                  bm_we, bm_re;
  logic [BM_ADDR_W-1:0]  bm_waddr, bm_raddr;
  logic [WORD_W-1:0]     bm_wdata, bm_rdata;

  logic                  accept, eval_go, start_fill;
  logic [CONN_IDX_W-1:0] in_idx;
  cnt_t                  cnt, cnt_new;
  logic [SEQ_W-1:0]      gap_lo, gap_hi;
  logic [BIT_W-1:0]      lo_bit, hi_bit;
  logic [WORD_W-1:0]     fill_mask;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign eval_go   = (state == ST_EVAL) && res_ready;
  assign res_valid = eval_go;
  assign in_idx    = CONN_IDX_W'(in_conn);
  assign cnt       = cnt_t'(cnt_rdata);
  assign gap_lo    = cnt.rel_recv + 16'd1;
  assign gap_hi    = seq_r - 16'd1;

  // bits of the current fill word that lie inside the skipped range
  assign lo_bit    = fill_first ? fill_lo : '0;
  assign hi_bit    = (fill_word == fill_end) ? fill_hi : BIT_W'(WORD_W - 1);
  assign fill_mask = ({WORD_W{1'b1}} << lo_bit)
                   & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));

  always_comb begin
    cnt_new    = cnt;
    cnt_we     = 1'b0;
    cnt_waddr  = conn_r;
    cnt_re     = accept;
    cnt_raddr  = in_idx;
    bm_we      = 1'b0;
    bm_waddr   = {conn_r, seq_r[SEQ_W-1:BIT_W]};
    bm_wdata   = bm_rdata & ~(WORD_W'(1) << seq_r[BIT_W-1:0]);
    bm_re      = accept;
    bm_raddr   = {in_idx, in_seq[SEQ_W-1:BIT_W]};
    res        = '0;
    start_fill = 1'b0;

    case (state)
      ST_CLEAR: begin
        bm_we     = 1'b1;
        bm_waddr  = clr_addr;
        bm_wdata  = '0;
        cnt_we    = (int'(clr_addr) < CONNECTIONS);
        cnt_waddr = CONN_IDX_W'(clr_addr);
        cnt_new   = '0;
      end
      ST_EVAL: begin
        if (conn_ok_r) begin
          case (op_r)
            OP_SYNC: begin
              cnt_we  = eval_go;
              cnt_new = '0;
            end
            OP_SEND_REL: begin
              cnt_we              = eval_go;
              cnt_new.rel_sent    = cnt.rel_sent + 16'd1;
              res.assigned_number = cnt_new.rel_sent;
              res.peer_last       = cnt.rel_recv;
            end
            OP_SEND_STR: begin
              cnt_we              = eval_go;
              cnt_new.str_sent    = cnt.str_sent + 16'd1;
              res.assigned_number = cnt_new.str_sent;
              res.peer_last       = cnt.str_recv;
            end
            OP_RECV_REL: begin
              res.peer_last = cnt.rel_recv;
              if (is_newer(seq_r, cnt.rel_recv)) begin
                res.fresh        = 1'b1;
                res.peer_last    = seq_r;
                cnt_we           = eval_go;
                cnt_new.rel_recv = seq_r;
                // numbers skipped over get marked, first word fetched now
                if (seq_r != gap_lo) begin
                  start_fill = 1'b1;
                  bm_re      = eval_go;
                  bm_raddr   = {conn_r, gap_lo[SEQ_W-1:BIT_W]};
                end
              end else if ((seq_r != cnt.rel_recv) && bm_rdata[seq_r[BIT_W-1:0]]) begin
                // late arrival of a number still marked missing
                res.fresh = 1'b1;
                bm_we     = eval_go;
              end
            end
            OP_RECV_STR: begin
              res.peer_last = cnt.str_recv;
              if (is_newer(seq_r, cnt.str_recv)) begin
                res.fresh        = 1'b1;
                res.peer_last    = seq_r;
                cnt_we           = eval_go;
                cnt_new.str_recv = seq_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        // write this word back while the next one is read
        bm_we    = 1'b1;
        bm_waddr = {conn_r, fill_word};
        bm_wdata = bm_rdata | fill_mask;
        bm_re    = (fill_word != fill_end);
        bm_raddr = {conn_r, fill_word + WIDX_W'(1)};
      end
      default: begin
      end
    endcase
  end

  assign cnt_wdata = cnt_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + BM_ADDR_W'(1);
          if (clr_addr == BM_ADDR_W'(BM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (eval_go) begin
            state <= start_fill ? ST_FILL : ST_IDLE;
          end
        end
        ST_FILL: begin
          if (fill_word == fill_end) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      conn_r    <= in_idx;
      conn_ok_r <= (int'(in_conn) < CONNECTIONS);
      seq_r     <= in_seq;
    end
    if (eval_go && start_fill) begin
      fill_word  <= gap_lo[SEQ_W-1:BIT_W];
      fill_end   <= gap_hi[SEQ_W-1:BIT_W];
      fill_lo    <= gap_lo[BIT_W-1:0];
      fill_hi    <= gap_hi[BIT_W-1:0];
      fill_first <= 1'b1;
    end else if (state == ST_FILL) begin
      fill_word  <= fill_word + WIDX_W'(1);
      fill_first <= 1'b0;
    end
  end

  sft_ram #(
    .WIDTH ($bits(cnt_t)),
    .DEPTH (CONNECTIONS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  sft_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BM_DEPTH)
  ) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

`ifndef NO_ASSERTIONS
  a_bm_no_same_addr: assert property (@(posedge clk) disable iff (rst)
    (bm_we && bm_re) |-> (bm_waddr != bm_raddr))
    else $error("bitmap read and write hit the same word");

  a_fill_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> ($past(state) == ST_EVAL || $past(state) == ST_FILL))
    else $error("gap fill entered without a newer reliable number");

  a_cnt_write_valid_conn: assert property (@(posedge clk) disable iff (rst)
    (cnt_we && state == ST_EVAL) |-> conn_ok_r)
    else $error("counter written for an out-of-range connection");

  a_fill_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (!res_valid && !in_ready))
    else $error("item activity during gap fill");
`endif

endmodule

/* design/sequence_freshness_tracker_core.sv */
`timescale 1ns / 1ps
// sequence freshness tracker: per-connection 16-bit cyclic send/receive counters
// and a missing-number bitmap for reliable traffic
// s_axis carries one command per transfer: s_axis_tuser is the operation
// (sync, send reliable, send stream, receive reliable, receive stream), s_axis_tdata
// the connection and the received sequence number
// m_axis returns exactly one result per command, in order: fresh flag on
// m_axis_tuser, assigned out-number and matching last-received number on m_axis_tdata
// result path: a command is evaluated after its transfer and its result is
// registered in the output register, from which it transfers on m_axis
// command flow: a command is taken only once the previous one is done, set by the
// counter read-modify-write (read in the accept cycle, update and result in evaluate);
// a reliable number that skips ahead adds a fill step per 64-bit bitmap word of the gap
// (up to 513 words), one read and one write of the bitmap memory per cycle
// reset: rst (synchronous) starts a clearing pass over the whole bitmap memory
// (CONNECTIONS*1024 = 16384 words) and the counters, s_axis_tready stays low meanwhile
// stall: the result sits in the output register; the next command is still taken
// and evaluated, and waits in its update cycle only while that register holds an untaken result
module sequence_freshness_tracker_core
  import sft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [3:0] connection, [19:4] sequence_req, rest zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] assigned_number, [31:16] peer_last
  output logic [0:0]  m_axis_tuser   // [0] fresh
);

  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_r;

  // output register frees when the downstream takes the pending transfer
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  sft_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_conn   (s_axis_tdata[CONN_W-1:0]),
    .in_seq    (s_axis_tdata[CONN_W+SEQ_W-1:CONN_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign m_axis_tdata = {out_r.peer_last, out_r.assigned_number};
  assign m_axis_tuser = out_r.fresh;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the sequence freshness tracker
module tb_top;
  import sft_pkg::*;

  // operation codes the block does not define, result must be all zero
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam int RANDOM_CMDS = 480;
  localparam int CALM_TAIL   = 50;     // last commands run with no idling
  localparam int STALL_LIMIT = 50000;  // covers the bitmap clearing pass after reset
  localparam int DRAIN_WAIT  = 10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CONN_W-1:0] conn;
    logic [SEQ_W-1:0]  seq;
  } tracker_cmd_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [3:0] connection, [19:4] sequence_req, rest zero
  logic [2:0]  s_axis_tuser = '0;  // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // [15:0] assigned_number, [31:16] peer_last
  logic [0:0]  m_axis_tuser;       // [0] fresh

  sequence_freshness_tracker_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // commands waiting to be sent, and results the block still owes
  tracker_cmd_t pending_cmds[$];
  res_t         awaited_results[$];

  // predicted block state
  logic [SEQ_W-1:0]  rel_sent_cnt [CONNECTIONS];
  logic [SEQ_W-1:0]  str_sent_cnt [CONNECTIONS];
  logic [SEQ_W-1:0]  rel_recv_cnt [CONNECTIONS];
  logic [SEQ_W-1:0]  str_recv_cnt [CONNECTIONS];
  bit   [WORD_W-1:0] missing_map  [BM_DEPTH];

  // stimulus-side view of the last received numbers, steers the random part
  logic [SEQ_W-1:0] gen_rel_last [CONNECTIONS];
  logic [SEQ_W-1:0] gen_str_last [CONNECTIONS];

  int  mismatch_count = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  sink_stall = 0;
  bit  cmd_taken = 1'b0;

  // true when a is ahead of b by 1..32767 modulo 2^16
  function automatic bit seq_ahead(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = a - b;
    return (diff != 0) && (diff < 16'h8000);
  endfunction

  // applies one command to the predicted state and returns the result it must give
  function automatic res_t track_freshness(tracker_cmd_t c);
    res_t             r;
    logic [SEQ_W-1:0] prev;
    logic [SEQ_W-1:0] k;
    r = '0;
    if (c.conn < CONNECTIONS) begin
      case (c.op)
        OP_SYNC: begin
          // marks stay, only the counters go back to zero
          rel_sent_cnt[c.conn] = '0;
          str_sent_cnt[c.conn] = '0;
          rel_recv_cnt[c.conn] = '0;
          str_recv_cnt[c.conn] = '0;
        end
        OP_SEND_REL: begin
          rel_sent_cnt[c.conn] = rel_sent_cnt[c.conn] + 16'd1;
          r.assigned_number = rel_sent_cnt[c.conn];
          r.peer_last = rel_recv_cnt[c.conn];
        end
        OP_SEND_STR: begin
          str_sent_cnt[c.conn] = str_sent_cnt[c.conn] + 16'd1;
          r.assigned_number = str_sent_cnt[c.conn];
          r.peer_last = str_recv_cnt[c.conn];
        end
        OP_RECV_REL: begin
          prev = rel_recv_cnt[c.conn];
          if (seq_ahead(c.seq, prev)) begin
            r.fresh = 1'b1;
            // every number jumped over is now missing
            for (k = prev + 16'd1; k != c.seq; k = k + 16'd1)
              missing_map[{c.conn, k[15:6]}][k[5:0]] = 1'b1;
            rel_recv_cnt[c.conn] = c.seq;
          end else if (c.seq != prev && missing_map[{c.conn, c.seq[15:6]}][c.seq[5:0]]) begin
            // late arrival of a missing number
            r.fresh = 1'b1;
            missing_map[{c.conn, c.seq[15:6]}][c.seq[5:0]] = 1'b0;
          end
          r.peer_last = rel_recv_cnt[c.conn];
        end
        OP_RECV_STR: begin
          if (seq_ahead(c.seq, str_recv_cnt[c.conn])) begin
            r.fresh = 1'b1;
            str_recv_cnt[c.conn] = c.seq;
          end
          r.peer_last = str_recv_cnt[c.conn];
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic add_cmd(logic [OP_W-1:0] op, logic [CONN_W-1:0] conn, logic [SEQ_W-1:0] seq);
    tracker_cmd_t c;
    c.op = op;
    c.conn = conn;
    c.seq = seq;
    pending_cmds.push_back(c);
    case (op)
      OP_SYNC: begin
        gen_rel_last[conn] = '0;
        gen_str_last[conn] = '0;
      end
      OP_RECV_REL: if (seq_ahead(seq, gen_rel_last[conn])) gen_rel_last[conn] = seq;
      OP_RECV_STR: if (seq_ahead(seq, gen_str_last[conn])) gen_str_last[conn] = seq;
      default: ;
    endcase
  endtask

  // mostly in-order traffic with gaps and late numbers, plus some noise
  task automatic add_random_cmd();
    logic [CONN_W-1:0] conn;
    logic [SEQ_W-1:0]  last;
    logic [SEQ_W-1:0]  seq;
    int                pick;
    int                how;
    // a few hot connections get long sequences
    conn = CONN_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    how  = $urandom_range(0, 99);
    seq  = SEQ_W'($urandom);
    if (pick < 4) begin
      add_cmd(OP_SYNC, conn, seq);
    end else if (pick < 16) begin
      add_cmd(OP_SEND_REL, conn, seq);
    end else if (pick < 26) begin
      add_cmd(OP_SEND_STR, conn, seq);
    end else if (pick < 70) begin
      last = gen_rel_last[conn];
      if (how < 45)      seq = last + 16'd1;
      else if (how < 65) seq = last + 16'($urandom_range(2, 70));
      else if (how < 80) seq = last - 16'($urandom_range(1, 150));   // probe marks
      else if (how < 85) seq = last;
      else if (how < 88) seq = last + 16'h8000;
      else if (how < 92) seq = last + 16'($urandom_range(71, 32767)); // long gap fill
      add_cmd(OP_RECV_REL, conn, seq);
    end else if (pick < 95) begin
      last = gen_str_last[conn];
      if (how < 50)      seq = last + 16'd1;
      else if (how < 70) seq = last + 16'($urandom_range(2, 1000));
      else if (how < 85) seq = last - 16'($urandom_range(0, 100));
      add_cmd(OP_RECV_STR, conn, seq);
    end else begin
      add_cmd(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)), conn, seq);
    end
  endtask

  // command side: next transfer goes out on the falling edge
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || cmd_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() > CALM_TAIL && (pending_cmds.size() / 64) % 3 != 0 &&
                   $urandom_range(0, 7) == 0) begin
        // idle burst: hold tvalid low and draw a new send_gap
        send_gap <= $urandom_range(0, 18);
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pending_cmds[0].seq, pending_cmds[0].conn};
        s_axis_tuser  <= pending_cmds[0].op;
      end
    end
  end

  // result side: random backpressure bursts, none in quiet phases and the tail
  always @(negedge clk) begin
    if (!rst) begin
      if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        m_axis_tready <= 1'b0;
      end else if (pending_cmds.size() > CALM_TAIL && (pending_cmds.size() / 64) % 3 != 1 &&
                   $urandom_range(0, 9) == 0) begin
        sink_stall <= $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // transfers are seen on the rising edge: results checked first, then the new
  // command predicted, so a result never meets its own expectation in one edge
  always @(posedge clk) begin
    res_t         got;
    res_t         want;
    tracker_cmd_t c;
    cmd_taken = 1'b0;
    if (!rst) begin
      idle_cycles = idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        got.fresh           = m_axis_tuser[0];
        got.assigned_number = m_axis_tdata[15:0];
        got.peer_last       = m_axis_tdata[31:16];
        if (awaited_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.fresh !== want.fresh) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: fresh expected %b actual %b", $time, want.fresh, got.fresh);
          end
          if (got.assigned_number !== want.assigned_number) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: assigned_number expected %h actual %h", $time,
                     want.assigned_number, got.assigned_number);
          end
          if (got.peer_last !== want.peer_last) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: peer_last expected %h actual %h", $time,
                     want.peer_last, got.peer_last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        idle_cycles = 0;
        cmd_taken = 1'b1;
        c = pending_cmds.pop_front();
        awaited_results.push_back(track_freshness(c));
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < CONNECTIONS; i++) begin
      rel_sent_cnt[i] = '0;
      str_sent_cnt[i] = '0;
      rel_recv_cnt[i] = '0;
      str_recv_cnt[i] = '0;
      gen_rel_last[i] = '0;
      gen_str_last[i] = '0;
    end

    // directed: sends, gaps and late numbers, repeats, half-cycle distance
    add_cmd(OP_SEND_REL, 4'd0, 16'h0000);
    add_cmd(OP_SEND_STR, 4'd0, 16'hFFFF);
    add_cmd(OP_RECV_REL, 4'd0, 16'd5);
    add_cmd(OP_RECV_REL, 4'd0, 16'd3);      // was marked missing
    add_cmd(OP_RECV_REL, 4'd0, 16'd3);      // mark already cleared
    add_cmd(OP_RECV_REL, 4'd0, 16'd5);      // repeat of the last number
    add_cmd(OP_RECV_REL, 4'd0, 16'h8005);   // half a cycle away counts as older
    add_cmd(OP_RECV_STR, 4'd0, 16'd10);
    add_cmd(OP_RECV_STR, 4'd0, 16'd10);
    add_cmd(OP_RECV_STR, 4'd0, 16'h800A);
    add_cmd(OP_RECV_STR, 4'd0, 16'hFFFF);
    add_cmd(OP_SEND_REL, 4'd0, 16'h5555);
    add_cmd(OP_SEND_STR, 4'd0, 16'hAAAA);
    // undefined operations
    add_cmd(OP_UNDEF_LO, 4'd15, 16'hFFFF);
    add_cmd(OP_UNDEF_LO + 3'd1, 4'd7, 16'hAAAA);
    add_cmd(OP_UNDEF_HI, 4'd8, 16'h5555);
    // marks survive a sync
    add_cmd(OP_SYNC, 4'd0, 16'h0000);
    add_cmd(OP_RECV_REL, 4'd0, 16'd2);
    add_cmd(OP_RECV_REL, 4'd0, 16'd1);      // marked missing again by the gap before 2
    add_cmd(OP_RECV_REL, 4'd0, 16'd4);
    // widest gaps and the counter wrap
    add_cmd(OP_RECV_REL, 4'd15, 16'h7FFF);
    add_cmd(OP_RECV_REL, 4'd15, 16'hFFFE);
    add_cmd(OP_RECV_REL, 4'd15, 16'h0003);
    add_cmd(OP_RECV_REL, 4'd15, 16'hFFFF);
    add_cmd(OP_RECV_STR, 4'd15, 16'h8000);
    add_cmd(OP_SYNC, 4'd15, 16'hFFFF);

    for (int n = 0; n < RANDOM_CMDS; n++)
      add_random_cmd();

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    wait (pending_cmds.size() == 0 && awaited_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* sequence_freshness_tracker_core.f */
design/sft_pkg.sv
design/sft_ram.sv
design/sft_engine.sv
design/sequence_freshness_tracker_core.sv
tb/tb_top.sv
